[hw/rtl/bse_pkg.sv]
package bse_pkg;

    // Characters that appear in escaped output.
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_TWO       = 8'h32;
    localparam logic [7:0] CH_ZERO      = 8'h30;

    // Control bytes that are always escaped.
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;

    // Letters that follow the backslash for control bytes.
    localparam logic [7:0] LTR_N = 8'h6E;
    localparam logic [7:0] LTR_T = 8'h74;
    localparam logic [7:0] LTR_R = 8'h72;
    localparam logic [7:0] LTR_V = 8'h76;
    localparam logic [7:0] LTR_F = 8'h66;
    localparam logic [7:0] LTR_A = 8'h61;
    localparam logic [7:0] LTR_B = 8'h62;

    // Longest escape sequence and configuration port sizes.
    localparam int SEQ_LEN    = 4;
    localparam int IDX_W      = 2;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address divided by four).
    typedef enum logic [1:0] {
        REG_ESCAPE_SPACE    = 2'd0,
        REG_ESCAPE_COLON    = 2'd1,
        REG_ESCAPE_BRACKETS = 2'd2,
        REG_UNUSED          = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic escape_space;
        logic escape_colon;
        logic escape_brackets;
    } cfg_t;

    // One decoded escape sequence: bytes in order, index of the final byte.
    typedef struct packed {
        logic [SEQ_LEN-1:0][7:0] bytes;
        logic [IDX_W-1:0]        last_idx;
    } seq_t;

endpackage

[hw/rtl/bse_cfg.sv]
module bse_cfg
    import bse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_ESCAPE_SPACE:    cfg_next.escape_space    = pwdata[0];
                REG_ESCAPE_COLON:    cfg_next.escape_colon    = pwdata[0];
                REG_ESCAPE_BRACKETS: cfg_next.escape_brackets = pwdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_ESCAPE_SPACE:    prdata[0] = cfg_reg.escape_space;
            REG_ESCAPE_COLON:    prdata[0] = cfg_reg.escape_colon;
            REG_ESCAPE_BRACKETS: prdata[0] = cfg_reg.escape_brackets;
            default:             prdata    = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/bse_decode.sv]
module bse_decode
    import bse_pkg::*;
(
    input  logic [7:0] byte_in,
    input  cfg_t       cfg,
    output seq_t       seq
);

    logic [7:0] letter;
    logic       is_ctrl;

    always_comb begin
        is_ctrl = 1'b1;
        case (byte_in)
            CH_NL:        letter = LTR_N;
            CH_TAB:       letter = LTR_T;
            CH_BACKSLASH: letter = CH_BACKSLASH;
            CH_CR:        letter = LTR_R;
            CH_VT:        letter = LTR_V;
            CH_FF:        letter = LTR_F;
            CH_BEL:       letter = LTR_A;
            CH_BS:        letter = LTR_B;
            default: begin
                letter  = 8'h00;
                is_ctrl = 1'b0;
            end
        endcase
    end

    // Control bytes take priority over the optional escapes.
    always_comb begin
        seq.bytes    = '0;
        seq.last_idx = IDX_W'(0);
        if (is_ctrl) begin
            seq.bytes[0] = CH_BACKSLASH;
            seq.bytes[1] = letter;
            seq.last_idx = IDX_W'(1);
        end else if (cfg.escape_space && byte_in == CH_SPACE) begin
            seq.bytes[0] = CH_BACKSLASH;
            seq.bytes[1] = CH_X;
            seq.bytes[2] = CH_TWO;
            seq.bytes[3] = CH_ZERO;
            seq.last_idx = IDX_W'(3);
        end else if ((cfg.escape_colon && byte_in == CH_COLON) ||
                     (cfg.escape_brackets && (byte_in == CH_LT || byte_in == CH_GT))) begin
            seq.bytes[0] = CH_BACKSLASH;
            seq.bytes[1] = byte_in;
            seq.last_idx = IDX_W'(1);
        end else begin
            seq.bytes[0] = byte_in;
        end
    end

endmodule

[hw/rtl/backslash_escape_encoder.sv]
// Backslash escape encoder: one input byte in, one to four escaped bytes out.
// Each accepted item is held in the sequence register, and its bytes pass one
// at a time through the output register to the result stream.
// Throughput: one result byte per cycle while m_tready holds; an item gives
// 1, 2 or 4 result bytes, set by the length of its escape sequence.
// Reset (aresetn low, synchronous) empties both stages and clears all three
// escape enables to zero.
module backslash_escape_encoder
    import bse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Input stream: tdata = {byte_in[7:0]}
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,

    // Result stream: tdata = {byte_out[7:0]}, tlast = last
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,

    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;
    seq_t seq_dec;

    bse_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The escape sequence is worked out as the item enters, so the sequence
    // register holds the whole expansion and only has to be walked through.
    bse_decode u_decode (
        .byte_in (s_tdata),
        .cfg     (cfg),
        .seq     (seq_dec)
    );

    // Sequence stage: the decoded bytes of one item and a read pointer.
    seq_t             seq_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             busy_reg;
    logic             busy_next;

    // Output stage: the result register that drives the master port.
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_data_reg;
    logic [7:0]       out_data_next;
    logic             out_last_reg;
    logic             out_last_next;

    logic             out_adv;
    logic             seq_done;
    logic             in_acc;

    // The output register can take a new byte when it is empty or its byte
    // is being taken this cycle.
    assign out_adv  = !out_valid_reg || m_tready;
    // The final byte of the held sequence moves to the output this cycle.
    assign seq_done = busy_reg && out_adv && (idx_reg == seq_reg.last_idx);
    // A new item enters as soon as the sequence stage empties or is about to.
    assign s_tready = !busy_reg || seq_done;
    assign in_acc   = s_tvalid && s_tready;

    always_comb begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (out_adv) begin
            out_valid_next = busy_reg;
            out_data_next  = seq_reg.bytes[idx_reg];
            out_last_next  = (idx_reg == seq_reg.last_idx);
            if (busy_reg) begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end

        if (seq_done) begin
            busy_next = 1'b0;
        end
        if (in_acc) begin
            busy_next = 1'b1;
            idx_next  = IDX_W'(0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            seq_reg <= seq_dec;
        end
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // An accepted item always leaves the sequence stage holding work.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> busy_reg)
        else $error("sequence stage empty after accepting an item");

    // The read pointer never runs past the final byte of the sequence.
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg <= seq_reg.last_idx))
        else $error("sequence pointer beyond final byte");

    // A shown byte that is not the last one still has its remainder pending.
    a_rest_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> busy_reg)
        else $error("non-final byte shown with no remaining sequence");

    // Only escape sequence bytes can be non-final.
    a_nonlast_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |->
            (m_tdata == CH_BACKSLASH || m_tdata == CH_X || m_tdata == CH_TWO))
        else $error("unexpected non-final byte value");

endmodule
